[src/irt_pkg.sv]
// ----------------------------------------------------------------------------
// irt_pkg: shared types for the interval reservation table
// Defines the request and response transfer payloads and the outcome codes.
// ----------------------------------------------------------------------------
`default_nettype none

package irt_pkg;

  // Outcome of one request
  typedef enum logic [1:0] {
    OUT_BOOKED  = 2'd0,
    OUT_OVERLAP = 2'd1,
    OUT_FULL    = 2'd2,
    OUT_INVALID = 2'd3
  } outcome_e;

  // Request payload: half-open range [range_start, range_end)
  typedef struct packed {
    logic [31:0] range_start;
    logic [31:0] range_end;
  } in_t;

  // Response payload
  typedef struct packed {
    outcome_e    outcome;
    logic [6:0]  entries_held;
  } out_t;

endpackage : irt_pkg

`default_nettype wire

[src/irt_ram.sv]
// ----------------------------------------------------------------------------
// irt_ram: simple dual-port RAM for the reservation table
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module irt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : irt_ram

`default_nettype wire

[src/interval_reservation_table_core.sv]
// ----------------------------------------------------------------------------
// interval_reservation_table_core: booking table of half-open time ranges
// Keeps non-overlapping ranges sorted by start and books or rejects requests.
// ----------------------------------------------------------------------------
// Each request transfer carries a range [range_start, range_end), both taken
// modulo 2^TIME_BITS (at most 32 bits are kept). An empty or reversed range
// returns outcome invalid; a range overlapping any stored one returns overlap;
// a fitting range with MAX_RANGES already stored returns full; otherwise the
// range is inserted at its sorted place and booked. Every request yields one
// response carrying the outcome and the number of stored ranges, masked to
// 7 bits. The table sits in a single-read, single-write RAM and one compare
// unit walks it: a well-formed request first scans every stored range, then,
// when booked, shifts the entries that do not start before the new range up
// by one and inserts it, and finally loads the response register. The RAM
// read port reads one entry per cycle. The request side is ready only while
// the sequencer is idle; a finished response waits in the output register
// while the next request is taken. No clearing pass is needed after reset:
// only entries below the count are ever read.
`default_nettype none

module interval_reservation_table_core #(
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  irt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output irt_pkg::out_t out_data_o
);

  import irt_pkg::*;

  // Kept time width: the payload fields carry 32 bits
  localparam int unsigned TW = (TIME_BITS < 32) ? TIME_BITS : 32;
  // RAM address width and entry count width
  localparam int unsigned AW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_PUT   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  // Control state
  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            pend_q, pend_d;       // a RAM read is in flight
  logic            out_valid_q, out_valid_d;

  // Working registers
  logic [TW-1:0]   a_q, a_d;             // requested start
  logic [TW-1:0]   b_q, b_d;             // requested end
  logic [CW-1:0]   idx_q, idx_d;         // scan index, then shift destination cursor
  logic [CW-1:0]   dest_q, dest_d;       // write slot of the word in flight
  logic [CW-1:0]   pos_q, pos_d;         // insertion position
  logic            ovl_q, ovl_d;         // overlap seen during the scan
  outcome_e        code_q, code_d;
  out_t            out_q, out_d;

  // RAM port
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [2*TW-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [2*TW-1:0] ram_rdata;
  logic [TW-1:0]   rd_start;
  logic [TW-1:0]   rd_end;

  logic            issue;
  logic [CW-1:0]   idx_dec;
  logic [CW+6:0]   held_ext;

  assign rd_start = ram_rdata[2*TW-1:TW];
  assign rd_end   = ram_rdata[TW-1:0];
  assign idx_dec  = idx_q - CW'(1);
  assign held_ext = {7'b0, count_q};

  irt_ram #(
    .DEPTH(MAX_RANGES),
    .WIDTH(2 * TW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q;
    a_d         = a_q;
    b_d         = b_q;
    idx_d       = idx_q;
    dest_d      = dest_q;
    pos_d       = pos_q;
    ovl_d       = ovl_q;
    code_d      = code_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;
    issue       = 1'b0;

    // Drop the response once it has been taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          a_d   = in_data_i.range_start[TW-1:0];
          b_d   = in_data_i.range_end[TW-1:0];
          idx_d = '0;
          pos_d = '0;
          ovl_d = 1'b0;
          if (in_data_i.range_end[TW-1:0] <= in_data_i.range_start[TW-1:0]) begin
            code_d  = OUT_INVALID;
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Read one stored entry per cycle, compare it the cycle after
        issue = (idx_q != count_q);
        if (issue) begin
          ram_raddr = idx_q[AW-1:0];
          idx_d     = idx_q + CW'(1);
        end
        pend_d = issue;
        if (pend_q) begin
          if ((rd_start < b_q) && (rd_end > a_q)) begin
            ovl_d = 1'b1;
          end
          if (rd_start < a_q) begin
            pos_d = pos_q + CW'(1);
          end
        end
        if (!issue && !pend_q) begin
          if (ovl_q) begin
            code_d  = OUT_OVERLAP;
            state_d = S_DONE;
          end else if (count_q == CW'(MAX_RANGES)) begin
            code_d  = OUT_FULL;
            state_d = S_DONE;
          end else begin
            idx_d   = count_q;
            state_d = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // Move entries pos..count-1 up by one, top entry first
        issue = (idx_q != pos_q);
        if (issue) begin
          ram_raddr = idx_dec[AW-1:0];
          dest_d    = idx_q;
          idx_d     = idx_dec;
        end
        pend_d = issue;
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = dest_q[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (!issue && !pend_q) begin
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = {a_q, b_q};
        count_d   = count_q + CW'(1);
        code_d    = OUT_BOOKED;
        state_d   = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.outcome      = code_q;
          out_d.entries_held = held_ext[6:0];
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    idx_q  <= idx_d;
    dest_q <= dest_d;
    pos_q  <= pos_d;
    ovl_q  <= ovl_d;
    code_q <= code_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : interval_reservation_table_core

`default_nettype wire

[src/irt_checker.sv]
// ----------------------------------------------------------------------------
// irt_checker: port-level checks for the interval reservation table
// Watches the request and response transfers of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module irt_checker #(
  parameter int unsigned MAX_RANGES = 64
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire irt_pkg::out_t out_data_o
);

  import irt_pkg::*;

  // A stalled response holds its payload
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("response changed while stalled");

  // The sequencer is busy right after taking a request
  a_busy_after_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request side ready right after a transfer");

  // Full is reported only with the table at capacity
  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.outcome == OUT_FULL) && (MAX_RANGES < 128))
      |-> (out_data_o.entries_held == 7'(MAX_RANGES)))
    else $error("full outcome with table below capacity");

  // A booking leaves at least one range stored
  a_booked_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.outcome == OUT_BOOKED) && (MAX_RANGES < 128))
      |-> (out_data_o.entries_held != 7'd0))
    else $error("booked outcome with empty table");

endmodule : irt_checker

bind interval_reservation_table_core irt_checker #(
  .MAX_RANGES(MAX_RANGES)
) u_irt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
